// File: rtl/pcmdc_pkg.sv
package pcmdc_pkg;

   localparam int unsigned DEF_MAX_DECIMATION  = 16;
   localparam int unsigned DEF_MAX_FRAME_BYTES = 8;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_IS_16BIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_IS_STEREO = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_BYTES   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DECIMATION    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_IS_16BIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_IS_STEREO = 3'd5;

   localparam logic [7:0] SIGN_FLIP = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       src_is_16bit;
      logic       src_is_stereo;
      logic [3:0] frame_bytes;
      logic [4:0] decimation;
      logic       out_is_16bit;
      logic       out_is_stereo;
   } cfg_type;

   function automatic logic [4:0] eff_decimation(input logic [4:0] dec,
                                                 input int unsigned max_dec);
      logic [4:0] res;
      if (dec == 5'd0) begin
         res = 5'd1;
      end else if (32'(dec) > max_dec) begin
         res = 5'(max_dec);
      end else begin
         res = dec;
      end
      return res;
   endfunction

endpackage

// File: rtl/pcmdc_fifo.sv
module pcmdc_fifo
   import pcmdc_pkg::*;
#(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Transaction pushed into a full queue.");
`endif

endmodule

// File: rtl/pcmdc_front.sv
module pcmdc_front
   import pcmdc_pkg::*;
#(
   parameter int unsigned MAX_DECIMATION  = DEF_MAX_DECIMATION,
   parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
   parameter int unsigned SUM_W           = 17 + $clog2(DEF_MAX_DECIMATION)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               accept,
   input  req_type            req_data,
   output logic               q_push,
   output logic [2*SUM_W-1:0] q_data
);

   localparam int unsigned PW = $clog2(MAX_FRAME_BYTES);

   logic [PW-1:0]    pos_ff, pos_in;
   logic [4:0]       frames_ff, frames_in;
   logic [SUM_W-1:0] lsum_ff, lsum_in;
   logic [SUM_W-1:0] rsum_ff, rsum_in;
   logic [7:0]       held_ff, held_in;

   logic [4:0]       fb_eff;
   logic [4:0]       dec_eff;
   logic [SUM_W-1:0] samp;
   logic [SUM_W-1:0] lsum_add, rsum_add;
   logic             add_l, add_r, take_low;
   logic             frame_done, group_done;
   logic [7:0]       b;

   assign b = req_data.data_byte;

   always_comb begin
      if (cfg.frame_bytes == 4'd0) begin
         fb_eff = 5'd1;
      end else if (32'(cfg.frame_bytes) > MAX_FRAME_BYTES) begin
         fb_eff = 5'(MAX_FRAME_BYTES);
      end else begin
         fb_eff = 5'(cfg.frame_bytes);
      end
   end

   assign dec_eff = eff_decimation(cfg.decimation, MAX_DECIMATION);

   always_comb begin
      add_l    = 1'b0;
      add_r    = 1'b0;
      take_low = 1'b0;
      if (cfg.src_is_16bit) begin
         samp = {{(SUM_W-16){b[7]}}, b, held_ff};
         if (pos_ff == PW'(0) || (pos_ff == PW'(2) && cfg.src_is_stereo)) begin
            take_low = 1'b1;
         end else if (pos_ff == PW'(1)) begin
            add_l = 1'b1;
            add_r = !cfg.src_is_stereo;
         end else if (pos_ff == PW'(3) && cfg.src_is_stereo) begin
            add_r = 1'b1;
         end
      end else begin
         samp = {{(SUM_W-8){1'b0}}, b};
         if (pos_ff == PW'(0)) begin
            add_l = 1'b1;
            add_r = !cfg.src_is_stereo;
         end else if (pos_ff == PW'(1) && cfg.src_is_stereo) begin
            add_r = 1'b1;
         end
      end
   end

   assign lsum_add   = add_l ? lsum_ff + samp : lsum_ff;
   assign rsum_add   = add_r ? rsum_ff + samp : rsum_ff;
   assign frame_done = (6'(pos_ff) + 6'd1) >= 6'(fb_eff);
   assign group_done = (6'(frames_ff) + 6'd1) >= 6'(dec_eff);

   assign q_push = accept && frame_done && group_done;
   assign q_data = {lsum_add, rsum_add};

   always_comb begin
      pos_in    = pos_ff;
      frames_in = frames_ff;
      lsum_in   = lsum_ff;
      rsum_in   = rsum_ff;
      held_in   = held_ff;
      if (accept) begin
         held_in = take_low ? b : held_ff;
         lsum_in = lsum_add;
         rsum_in = rsum_add;
         if (frame_done) begin
            pos_in = '0;
            if (group_done) begin
               frames_in = '0;
               lsum_in   = '0;
               rsum_in   = '0;
            end else begin
               frames_in = frames_ff + 5'd1;
            end
         end else begin
            pos_in = pos_ff + PW'(1);
         end
         if (req_data.end_of_chunk) begin
            pos_in    = '0;
            frames_in = '0;
            lsum_in   = '0;
            rsum_in   = '0;
            held_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         frames_ff <= '0;
         lsum_ff   <= '0;
         rsum_ff   <= '0;
         held_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         frames_ff <= frames_in;
         lsum_ff   <= lsum_in;
         rsum_ff   <= rsum_in;
         held_ff   <= held_in;
      end
   end

endmodule

// File: rtl/pcmdc_back.sv
module pcmdc_back
   import pcmdc_pkg::*;
#(
   parameter int unsigned MAX_DECIMATION = DEF_MAX_DECIMATION,
   parameter int unsigned SUM_W          = 17 + $clog2(DEF_MAX_DECIMATION)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_empty,
   input  logic [2*SUM_W-1:0] q_data,
   output logic               q_pop,
   input  logic               out_full,
   output logic               out_push,
   output rsp_type            out_data
);

   localparam int unsigned NW = $clog2(SUM_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   logic [SUM_W-1:0] lmag_ff, lmag_in, rmag_ff, rmag_in;
   logic [4:0]       lrem_ff, lrem_in, rrem_ff, rrem_in;
   logic             lneg_ff, lneg_in, rneg_ff, rneg_in;

   logic [SUM_W-1:0] lsum, rsum;
   logic [4:0]       dec_eff;
   logic [5:0]       lshift, rshift;
   logic             lfit, rfit;
   logic [15:0]      lavg, ravg, lconv, rconv, sel;
   logic [1:0]       last_idx;
   logic             chan, hi, is_last;

   function automatic logic [15:0] convert(input logic [15:0] avg,
                                           input logic src16, input logic out16);
      logic [15:0] res;
      if (src16 == out16) begin
         res = avg;
      end else if (out16) begin
         res = {avg[7:0] ^ SIGN_FLIP, 8'h00};
      end else begin
         res = {8'h00, avg[15:8] ^ SIGN_FLIP};
      end
      return res;
   endfunction

   assign lsum    = q_data[2*SUM_W-1:SUM_W];
   assign rsum    = q_data[SUM_W-1:0];
   assign dec_eff = eff_decimation(cfg.decimation, MAX_DECIMATION);

   assign lshift = {lrem_ff, lmag_ff[SUM_W-1]};
   assign rshift = {rrem_ff, rmag_ff[SUM_W-1]};
   assign lfit   = lshift >= {1'b0, dec_eff};
   assign rfit   = rshift >= {1'b0, dec_eff};

   assign lavg  = lneg_ff ? 16'(-lmag_ff) : lmag_ff[15:0];
   assign ravg  = rneg_ff ? 16'(-rmag_ff) : rmag_ff[15:0];
   assign lconv = convert(lavg, cfg.src_is_16bit, cfg.out_is_16bit);
   assign rconv = convert(ravg, cfg.src_is_16bit, cfg.out_is_16bit);

   assign last_idx = {cfg.out_is_16bit & cfg.out_is_stereo,
                      cfg.out_is_16bit | cfg.out_is_stereo};
   assign chan     = cfg.out_is_16bit ? idx_ff[1] : idx_ff[0];
   assign hi       = cfg.out_is_16bit & idx_ff[0];
   assign sel      = chan ? rconv : lconv;
   assign is_last  = (idx_ff == last_idx);

   assign q_pop                = (state_ff == ST_IDLE) && !q_empty;
   assign out_push             = (state_ff == ST_EMIT) && !out_full;
   assign out_data.out_byte    = hi ? sel[15:8] : sel[7:0];
   assign out_data.last_of_run = is_last;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      lmag_in  = lmag_ff;
      rmag_in  = rmag_ff;
      lrem_in  = lrem_ff;
      rrem_in  = rrem_ff;
      lneg_in  = lneg_ff;
      rneg_in  = rneg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               lneg_in  = lsum[SUM_W-1];
               rneg_in  = rsum[SUM_W-1];
               lmag_in  = lsum[SUM_W-1] ? -lsum : lsum;
               rmag_in  = rsum[SUM_W-1] ? -rsum : rsum;
               lrem_in  = '0;
               rrem_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            lrem_in = lfit ? 5'(lshift - {1'b0, dec_eff}) : lshift[4:0];
            rrem_in = rfit ? 5'(rshift - {1'b0, dec_eff}) : rshift[4:0];
            lmag_in = {lmag_ff[SUM_W-2:0], lfit};
            rmag_in = {rmag_ff[SUM_W-2:0], rfit};
            cnt_in  = cnt_ff + NW'(1);
            if (cnt_ff == NW'(SUM_W - 1)) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               idx_in = idx_ff + 2'd1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      lmag_ff <= lmag_in;
      rmag_ff <= rmag_in;
      lrem_ff <= lrem_in;
      rrem_ff <= rrem_in;
      lneg_ff <= lneg_in;
      rneg_ff <= rneg_in;
   end

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_DIV)
      else $error("Group taken from the queue without starting a division.");
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.last_of_run) |=> state_ff == ST_IDLE)
      else $error("Frame did not end after its final byte.");
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && $past(state_ff) == ST_IDLE) |-> cnt_ff == '0)
      else $error("Division started with a stale step count.");
   a_emit_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff <= last_idx)
      else $error("Byte index ran past the end of the output frame.");
`endif

endmodule

// File: rtl/pcm_decimate_depth_convert.sv
// PCM decimator and bit-depth converter. Data-chunk bytes enter one per transaction and are
// accepted one per cycle while req_full is low; req_full rises only while the two-entry group
// queue is full. Each completed group of frames is divided by the decimation count in an
// iterative divider that handles both channels together and yields one quotient bit per step
// over every bit of the running sum (21 bits wide at the default maximum decimation of 16),
// after which the output bytes of that frame are written one per cycle, while the four-entry
// result queue has room. The back end takes a new group only after the last byte of the
// previous frame (one to four bytes) is written. Configuration registers are written through
// csr_wen, csr_index and csr_wdata and must only change while no transaction is in flight.
module pcm_decimate_depth_convert
   import pcmdc_pkg::*;
#(
   parameter int unsigned MAX_DECIMATION  = DEF_MAX_DECIMATION,
   parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SUM_W = 17 + $clog2(MAX_DECIMATION);
   localparam int unsigned RSP_W = $bits(rsp_type);

   cfg_type            cfg_ff, cfg_in;
   logic               accept;
   logic               q_push, q_pop, q_full, q_empty;
   logic [2*SUM_W-1:0] q_wdata, q_rdata;
   logic               out_push, out_full;
   rsp_type            out_data;
   logic [RSP_W-1:0]   rsp_bits;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_SRC_IS_16BIT:  cfg_in.src_is_16bit  = csr_wdata[0];
            REG_SRC_IS_STEREO: cfg_in.src_is_stereo = csr_wdata[0];
            REG_FRAME_BYTES:   cfg_in.frame_bytes   = csr_wdata[3:0];
            REG_DECIMATION:    cfg_in.decimation    = csr_wdata[4:0];
            REG_OUT_IS_16BIT:  cfg_in.out_is_16bit  = csr_wdata[0];
            REG_OUT_IS_STEREO: cfg_in.out_is_stereo = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_is_16bit  <= 1'b1;
         cfg_ff.src_is_stereo <= 1'b1;
         cfg_ff.frame_bytes   <= 4'd4;
         cfg_ff.decimation    <= 5'd1;
         cfg_ff.out_is_16bit  <= 1'b1;
         cfg_ff.out_is_stereo <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   pcmdc_front #(
      .MAX_DECIMATION  (MAX_DECIMATION),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .SUM_W           (SUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   pcmdc_fifo #(
      .WIDTH (2*SUM_W),
      .DEPTH (2)
   ) u_group_q (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rdata)
   );

   pcmdc_back #(
      .MAX_DECIMATION (MAX_DECIMATION),
      .SUM_W          (SUM_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   pcmdc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (4)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule
